// ===== design/dual_bank_record_check_and_patch_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the dual bank record check and patch block
// Concurrent checks that are compiled out when NO_ASSERTIONS is defined.
// ----------------------------------------------------------------------------
`ifndef DUAL_BANK_RECORD_CHECK_AND_PATCH_MACROS_SVH
`define DUAL_BANK_RECORD_CHECK_AND_PATCH_MACROS_SVH
`ifndef NO_ASSERTIONS
// Antecedent implies consequent in the same cycle.
`define DBRC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dbrc check failed");
// Antecedent implies consequent in the next cycle.
`define DBRC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dbrc check failed");
// Expression never holds.
`define DBRC_ASSERT_NEVER(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("dbrc check failed");
`else
`define DBRC_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define DBRC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`define DBRC_ASSERT_NEVER(label, clk, rst_n, expr)
`endif
`endif

// ===== design/dbrc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dbrc_pkg
// Transaction types, command and status structs, constants and the CRC step.
// ----------------------------------------------------------------------------
package dbrc_pkg;

  localparam logic [31:0] CRC_POLY     = 32'h04C1_1DB7;
  localparam logic [31:0] CRC_INIT     = 32'hFFFF_FFFF;
  localparam int          UNLOCK_W     = 10;
  localparam logic [UNLOCK_W-1:0] UNLOCK_RESET = 10'd123;
  localparam int          PATCH_WORD   = 3;

  localparam logic [1:0] OUTCOME_CLEAN    = 2'd0;
  localparam logic [1:0] OUTCOME_DIFFERED = 2'd1;
  localparam logic [1:0] OUTCOME_HEALED   = 2'd2;
  localparam logic [1:0] OUTCOME_NONE     = 2'd3;

  typedef struct packed {
    logic [31:0] word_bank_a;
    logic [31:0] word_bank_b;
    logic        final_word;
  } in_item_t;

  typedef struct packed {
    logic [31:0] out_word;
    logic [7:0]  out_index;
    logic [1:0]  outcome;
    logic        run_end;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;     // input transaction accepted
    logic check;    // judge both records and clear the load state
    logic fetch;    // read the first word of the chosen record
    logic advance;  // a non-final result was taken, move to the next word
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic any_ok;
    logic last_word;
  } dp_status_t;

  // One 32-bit word through the MPEG-2 CRC-32, most significant bit first.
  function automatic logic [31:0] crc_word(input logic [31:0] crc, input logic [31:0] w);
    logic [31:0] c;
    c = crc ^ w;
    for (int i = 0; i < 32; i++) begin
      c = c[31] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage
`default_nettype wire

// ===== design/dbrc_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dbrc_ctrl
// Sequencer for the load, check, fetch and emit phases of one record run.
// ----------------------------------------------------------------------------
module dbrc_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  input  wire logic                in_final,
  output logic                     in_ready,
  output logic                     out_valid,
  input  wire logic                out_ready,
  input  wire dbrc_pkg::dp_status_t status,
  output dbrc_pkg::ctrl_cmd_t      cmd
);

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_CHECK,
    ST_FETCH,
    ST_EMIT,
    ST_FAIL
  } state_t;

  state_t state_r, state_nxt;
  logic   in_ready_r, in_ready_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   in_take;
  logic   out_take;

  assign in_take  = in_valid && in_ready_r;
  assign out_take = out_valid_r && out_ready;

  assign in_ready  = in_ready_r;
  assign out_valid = out_valid_r;

  assign cmd.load    = in_take;
  assign cmd.check   = (state_r == ST_CHECK);
  assign cmd.fetch   = (state_r == ST_FETCH);
  assign cmd.advance = (state_r == ST_EMIT) && out_take && !status.last_word;

  always_comb begin
    state_nxt     = state_r;
    in_ready_nxt  = in_ready_r;
    out_valid_nxt = out_valid_r;
    case (state_r)
      ST_LOAD: begin
        if (in_take && in_final) begin
          state_nxt    = ST_CHECK;
          in_ready_nxt = 1'b0;
        end
      end
      ST_CHECK: begin
        out_valid_nxt = !status.any_ok;
        state_nxt     = status.any_ok ? ST_FETCH : ST_FAIL;
      end
      ST_FETCH: begin
        state_nxt     = ST_EMIT;
        out_valid_nxt = 1'b1;
      end
      ST_EMIT: begin
        if (out_take && status.last_word) begin
          state_nxt     = ST_LOAD;
          out_valid_nxt = 1'b0;
          in_ready_nxt  = 1'b1;
        end
      end
      ST_FAIL: begin
        if (out_take) begin
          state_nxt     = ST_LOAD;
          out_valid_nxt = 1'b0;
          in_ready_nxt  = 1'b1;
        end
      end
      default: begin
        state_nxt     = ST_LOAD;
        out_valid_nxt = 1'b0;
        in_ready_nxt  = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      in_ready_r  <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      in_ready_r  <= in_ready_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== design/dbrc_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dbrc_dp
// Record stores, running CRCs, selection, patching and the result payload.
// ----------------------------------------------------------------------------
module dbrc_dp #(
  parameter int RECORD_LEN = 52
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire dbrc_pkg::in_item_t               in_data,
  input  wire logic                             cfg_we,
  input  wire logic [dbrc_pkg::UNLOCK_W-1:0]    cfg_unlock_code,
  input  wire dbrc_pkg::ctrl_cmd_t              cmd,
  output dbrc_pkg::dp_status_t                  status,
  output dbrc_pkg::out_item_t                   out_data
);

  localparam int CNT_W  = $clog2(RECORD_LEN + 1);
  localparam int ADDR_W = $clog2(RECORD_LEN);

  logic [31:0] mem_a [RECORD_LEN];
  logic [31:0] mem_b [RECORD_LEN];

  logic [CNT_W-1:0]             load_count_r, load_count_nxt;
  logic [31:0]                  crc_a_r, crc_a_nxt;
  logic [31:0]                  crc_b_r, crc_b_nxt;
  logic                         mismatch_r, mismatch_nxt;
  logic [dbrc_pkg::UNLOCK_W-1:0] unlock_code_r, unlock_code_nxt;

  logic              use_a_r, use_a_nxt;
  logic              fail_r, fail_nxt;
  logic [1:0]        code_r, code_nxt;
  logic [ADDR_W-1:0] last_idx_r, last_idx_nxt;
  logic [ADDR_W-1:0] k_r, k_nxt;
  logic [31:0]       emit_crc_r, emit_crc_nxt;
  logic [31:0]       mem_q_r;

  logic              store_en;
  logic              a_ok;
  logic              b_ok;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W-1:0] wr_addr;
  logic [31:0]       patched;
  logic              last;
  logic [31:0]       word_out;

  assign store_en = cmd.load && (load_count_r < CNT_W'(RECORD_LEN));
  assign wr_addr  = load_count_r[ADDR_W-1:0];
  assign a_ok     = (load_count_r != '0) && (crc_a_r == '0);
  assign b_ok     = (load_count_r != '0) && (crc_b_r == '0);

  assign rd_en   = cmd.fetch || cmd.advance;
  assign rd_addr = cmd.fetch ? k_r : ADDR_W'(k_r + 1'b1);

  assign patched = (k_r == ADDR_W'(dbrc_pkg::PATCH_WORD))
                 ? {mem_q_r[31:16], 16'(unlock_code_r)} : mem_q_r;
  assign last     = (k_r == last_idx_r);
  assign word_out = last ? emit_crc_r : patched;

  assign status.any_ok    = a_ok || b_ok;
  assign status.last_word = last;

  always_comb begin
    if (fail_r) begin
      out_data.out_word  = '0;
      out_data.out_index = '0;
      out_data.outcome   = dbrc_pkg::OUTCOME_NONE;
      out_data.run_end   = 1'b1;
    end else begin
      out_data.out_word  = word_out;
      out_data.out_index = 8'(k_r);
      out_data.outcome   = code_r;
      out_data.run_end   = last;
    end
  end

  always_comb begin
    load_count_nxt  = load_count_r;
    crc_a_nxt       = crc_a_r;
    crc_b_nxt       = crc_b_r;
    mismatch_nxt    = mismatch_r;
    unlock_code_nxt = cfg_we ? cfg_unlock_code : unlock_code_r;
    use_a_nxt       = use_a_r;
    fail_nxt        = fail_r;
    code_nxt        = code_r;
    last_idx_nxt    = last_idx_r;
    k_nxt           = k_r;
    emit_crc_nxt    = emit_crc_r;

    if (store_en) begin
      crc_a_nxt      = dbrc_pkg::crc_word(crc_a_r, in_data.word_bank_a);
      crc_b_nxt      = dbrc_pkg::crc_word(crc_b_r, in_data.word_bank_b);
      mismatch_nxt   = mismatch_r || (in_data.word_bank_a != in_data.word_bank_b);
      load_count_nxt = load_count_r + 1'b1;
    end

    if (cmd.check) begin
      use_a_nxt = a_ok;
      fail_nxt  = !(a_ok || b_ok);
      if (a_ok && b_ok && mismatch_r) begin
        code_nxt = dbrc_pkg::OUTCOME_DIFFERED;
      end else if (!a_ok || !b_ok) begin
        code_nxt = dbrc_pkg::OUTCOME_HEALED;
      end else begin
        code_nxt = dbrc_pkg::OUTCOME_CLEAN;
      end
      last_idx_nxt   = ADDR_W'(load_count_r - 1'b1);
      k_nxt          = '0;
      emit_crc_nxt   = dbrc_pkg::CRC_INIT;
      crc_a_nxt      = dbrc_pkg::CRC_INIT;
      crc_b_nxt      = dbrc_pkg::CRC_INIT;
      mismatch_nxt   = 1'b0;
      load_count_nxt = '0;
    end

    if (cmd.advance) begin
      emit_crc_nxt = dbrc_pkg::crc_word(emit_crc_r, patched);
      k_nxt        = ADDR_W'(k_r + 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_count_r  <= '0;
      crc_a_r       <= dbrc_pkg::CRC_INIT;
      crc_b_r       <= dbrc_pkg::CRC_INIT;
      mismatch_r    <= 1'b0;
      unlock_code_r <= dbrc_pkg::UNLOCK_RESET;
    end else begin
      load_count_r  <= load_count_nxt;
      crc_a_r       <= crc_a_nxt;
      crc_b_r       <= crc_b_nxt;
      mismatch_r    <= mismatch_nxt;
      unlock_code_r <= unlock_code_nxt;
    end
  end

  always_ff @(posedge clk) begin
    use_a_r    <= use_a_nxt;
    fail_r     <= fail_nxt;
    code_r     <= code_nxt;
    last_idx_r <= last_idx_nxt;
    k_r        <= k_nxt;
    emit_crc_r <= emit_crc_nxt;
  end

  // Both stores share one write address and one read address.
  always_ff @(posedge clk) begin
    if (store_en) begin
      mem_a[wr_addr] <= in_data.word_bank_a;
      mem_b[wr_addr] <= in_data.word_bank_b;
    end
    if (rd_en) begin
      mem_q_r <= use_a_r ? mem_a[rd_addr] : mem_b[rd_addr];
    end
  end

endmodule
`default_nettype wire

// ===== design/dual_bank_record_check_and_patch.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "dual_bank_record_check_and_patch_macros.svh"
// ----------------------------------------------------------------------------
// Dual bank record check and patch
// Checks two redundant configuration records by CRC, keeps a good one,
// patches the unlock code into word 3, re-signs it and streams it out.
// - The input channel takes one transaction per cycle, the words at the same
//   position in bank A and bank B; final_word marks the last pair. Pairs
//   beyond RECORD_LEN are accepted but ignored.
// - After the final pair in_ready stays low for the whole output run. The
//   CHECK state judges both CRCs and the FETCH state then reads the first
//   word of the good record before the first result appears; the N words
//   then leave back to back while out_ready is high.
// - If neither record is good, a single status transaction (outcome 3)
//   appears once the CHECK state has judged both CRCs.
// - in_ready rises again in the cycle after the last result is taken.
// - While a result is offered and out_ready is low, it and the run state hold.
// - Reset presets the CRCs, clears the word count and controller and sets the
//   unlock code to 123; record stores are not cleared. The cfg port is always
//   ready; the user must write it only between runs, unenforced by the block.
// ----------------------------------------------------------------------------
module dual_bank_record_check_and_patch #(
  parameter int RECORD_LEN = 52
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire dbrc_pkg::in_item_t            in_data,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output dbrc_pkg::out_item_t                out_data,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [dbrc_pkg::UNLOCK_W-1:0] cfg_unlock_code
);

  dbrc_pkg::ctrl_cmd_t  cmd;
  dbrc_pkg::dp_status_t status;

  // The register write is a single flop update, so the port never stalls.
  assign cfg_ready = 1'b1;

  dbrc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_final  (in_data.final_word),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  dbrc_dp #(
    .RECORD_LEN (RECORD_LEN)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_data         (in_data),
    .cfg_we          (cfg_valid && cfg_ready),
    .cfg_unlock_code (cfg_unlock_code),
    .cmd             (cmd),
    .status          (status),
    .out_data        (out_data)
  );

  // Loading and emitting are separate phases of a run.
  `DBRC_ASSERT_NEVER(a_phases_apart, clk, rst_n, in_ready && out_valid)

  // The final input transaction closes the input channel for the run.
  `DBRC_ASSERT_NEXT(a_final_closes, clk, rst_n,
                    in_valid && in_ready && in_data.final_word, !in_ready)

  // Taking the last result of a run reopens the input channel.
  `DBRC_ASSERT_NEXT(a_end_reopens, clk, rst_n,
                    out_valid && out_ready && out_data.run_end, in_ready && !out_valid)

  // A status-only result stands alone at position zero.
  `DBRC_ASSERT_SAME(a_none_alone, clk, rst_n,
                    out_valid && (out_data.outcome == dbrc_pkg::OUTCOME_NONE),
                    out_data.run_end && (out_data.out_index == 8'd0))

endmodule
`default_nettype wire
